[hw/rtl/flow_to_drive_interp_table_assert.svh]
// Assertion macros for the RTL of the flow to drive table.
`ifndef FLOW_TO_DRIVE_INTERP_TABLE_ASSERT_SVH
`define FLOW_TO_DRIVE_INTERP_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTDI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTDI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ftdi_pkg.sv]
package ftdi_pkg;

   localparam int MIN_FLOW_UNITS  = 2;
   localparam int FLOW_SPAN_UNITS = 8;
   localparam int DRIVE_BITS      = 12;

   localparam int OUT_BITS   = 12;
   localparam int NCELLS     = FLOW_SPAN_UNITS * 10;
   localparam int CELL_BITS  = $clog2(NCELLS);
   localparam int FLOW_LO    = MIN_FLOW_UNITS * 10;
   localparam int FLOW_HI    = (MIN_FLOW_UNITS + FLOW_SPAN_UNITS) * 10 - 1;

   // Distance between two cells in hundredths, and the interpolation sums.
   localparam int DIST_BITS     = $clog2(10 * NCELLS);
   localparam int PROD_BITS     = DRIVE_BITS + DIST_BITS;
   localparam int DIVIDEND_BITS = PROD_BITS + 1;
   localparam int DIVISOR_BITS  = DIST_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

   // Division of a 16-bit magnitude by ten as a reciprocal multiplication.
   localparam int RECIP       = 52429;
   localparam int RECIP_SHIFT = 19;
   localparam int ROUND_BIAS  = 5;
   localparam int TENTHS_BITS = 12;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [DIVISOR_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [DIVIDEND_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/ftdi_div.sv]
module ftdi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ftdi_pkg::div_req_type div_req,
   output ftdi_pkg::div_rsp_type div_rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [ftdi_pkg::DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [ftdi_pkg::DIVISOR_BITS-1:0]    rem_ff, rem_in;
   logic [ftdi_pkg::DIVISOR_BITS-1:0]    dvs_ff, dvs_in;
   logic [ftdi_pkg::DIVIDEND_BITS-1:0]   quo_ff, quo_in;
   logic [ftdi_pkg::DIVISOR_BITS:0]      trial;
   logic                                 fits;

   // One quotient bit per cycle: the dividend shifts out of the top of the quotient
   // register while the quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[ftdi_pkg::DIVIDEND_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = ftdi_pkg::DIVISOR_BITS'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = ftdi_pkg::DIVISOR_BITS'(trial);
         end
         quo_in = {quo_ff[ftdi_pkg::DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ftdi_pkg::DIV_CNT_BITS'(ftdi_pkg::DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[hw/rtl/flow_to_drive_interp_table.sv]
// Sparse pump drive calibration table with linear interpolation.
// Requests enter on req_valid/req_ready with req_type choosing clear, write or lookup.
// A clear or a write takes effect at acceptance and gives no response; req_ready
// stays high, so such requests may follow one another in every cycle.
// A lookup rounds the flow to tenths, clamps it to the table and answers on
// rsp_valid/rsp_ready with drive_out, drive_valid and exact_hit.
// An exact hit reads its cell and passes through ST_HIT and ST_DONE to rsp_valid. A miss walks the valid
// bits one cell per cycle, first downwards and then upwards from the rounded cell; an
// interpolation then reads both found cells, multiplies in ST_MUL1 and ST_MUL2, starts the
// divider in ST_DIVGO and waits in ST_DIV for a restoring division of DIVIDEND_BITS
// quotient bits before the result goes to ST_DONE.
// req_ready is low while a lookup is in progress; the next lookup may start as
// soon as the previous one has finished.
// The response sits in an output register; while the receiver stalls, further
// clears and writes are still taken, and a following lookup waits at its end for
// the register to free up.
// Reset empties the table at once by clearing the valid bit of every cell; the
// stored drive values are never read before they are written.
module flow_to_drive_interp_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic signed [15:0]            req_flow_centi,
   input  logic [6:0]                    req_cell_index,
   input  logic [11:0]                   req_drive_value,
   input  logic                          req_only_if_empty,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [11:0]                   rsp_drive_out,
   output logic                          rsp_drive_valid,
   output logic                          rsp_exact_hit
);

   `include "flow_to_drive_interp_table_assert.svh"

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CELL   = 4'd1;
   localparam logic [3:0] ST_SCANDN = 4'd2;
   localparam logic [3:0] ST_SCANUP = 4'd3;
   localparam logic [3:0] ST_RDLO   = 4'd4;
   localparam logic [3:0] ST_RDHI   = 4'd5;
   localparam logic [3:0] ST_MUL1   = 4'd6;
   localparam logic [3:0] ST_MUL2   = 4'd7;
   localparam logic [3:0] ST_DIVGO  = 4'd8;
   localparam logic [3:0] ST_DIV    = 4'd9;
   localparam logic [3:0] ST_HIT    = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [3:0]                           state_ff, state_in;
   logic [ftdi_pkg::NCELLS-1:0]          valid_ff, valid_in;
   logic [ftdi_pkg::CELL_BITS-1:0]       ptr_ff, ptr_in;
   logic [ftdi_pkg::CELL_BITS-1:0]       cell_ff, cell_in;
   logic [ftdi_pkg::CELL_BITS-1:0]       below_ff, below_in;
   logic [ftdi_pkg::CELL_BITS-1:0]       above_ff, above_in;
   logic                                 below_found_ff, below_found_in;
   logic                                 above_found_ff, above_found_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]                          flow_ff, flow_in;
   logic [ftdi_pkg::DIST_BITS-1:0]       dist_ff, dist_in;
   logic [ftdi_pkg::DIST_BITS-1:0]       xoff_ff, xoff_in;
   logic [ftdi_pkg::DRIVE_BITS-1:0]      lo_ff, lo_in;
   logic [ftdi_pkg::DRIVE_BITS-1:0]      hi_ff, hi_in;
   logic [ftdi_pkg::PROD_BITS-1:0]       acc_ff, acc_in;
   logic [ftdi_pkg::OUT_BITS-1:0]        res_drive_ff, res_drive_in;
   logic                                 res_valid_ff, res_valid_in;
   logic                                 res_exact_ff, res_exact_in;
   logic [ftdi_pkg::OUT_BITS-1:0]        rsp_drive_ff, rsp_drive_in;
   logic                                 rsp_dvalid_ff, rsp_dvalid_in;
   logic                                 rsp_exact_ff, rsp_exact_in;

   logic [ftdi_pkg::DRIVE_BITS-1:0]      mem [ftdi_pkg::NCELLS];
   logic [ftdi_pkg::DRIVE_BITS-1:0]      rd_data_ff;
   logic                                 rd_en;
   logic [ftdi_pkg::CELL_BITS-1:0]       rd_addr;
   logic                                 wr_en;
   logic [ftdi_pkg::CELL_BITS-1:0]       wr_addr;

   logic                                 accept;
   logic                                 wr_in_range;
   logic [ftdi_pkg::CELL_BITS-1:0]       wr_cell;
   logic [16:0]                          flow_mag;
   logic [16:0]                          flow_rnd;
   logic [33:0]                          recip_prod;
   logic [ftdi_pkg::TENTHS_BITS-1:0]     tenths;
   logic [ftdi_pkg::CELL_BITS-1:0]       cell_calc;
   logic signed [17:0]                   xoff_raw;
   logic signed [17:0]                   dist_signed;
   logic [ftdi_pkg::DIST_BITS-1:0]       dist_calc;
   logic [ftdi_pkg::DRIVE_BITS-1:0]      mul_a;
   logic [ftdi_pkg::DIST_BITS-1:0]       mul_b;
   logic [ftdi_pkg::PROD_BITS-1:0]       mul_p;
   logic                                 slot_free;
   ftdi_pkg::div_req_type                div_req;
   ftdi_pkg::div_rsp_type                div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign wr_in_range = 32'(req_cell_index) < ftdi_pkg::NCELLS;
   assign wr_cell     = ftdi_pkg::CELL_BITS'(req_cell_index);

   // Round half away from zero on the magnitude, then divide by ten.
   assign flow_mag   = flow_ff[15] ? (17'(~flow_ff) + 17'd1) : 17'(flow_ff);
   assign flow_rnd   = flow_mag + 17'(ftdi_pkg::ROUND_BIAS);
   assign recip_prod = 34'(flow_rnd) * 34'(ftdi_pkg::RECIP);
   assign tenths     = recip_prod[ftdi_pkg::RECIP_SHIFT +: ftdi_pkg::TENTHS_BITS];

   always_comb begin
      if (flow_ff[15] || (32'(tenths) < ftdi_pkg::FLOW_LO)) begin
         cell_calc = '0;
      end else if (32'(tenths) > ftdi_pkg::FLOW_HI) begin
         cell_calc = ftdi_pkg::CELL_BITS'(ftdi_pkg::NCELLS - 1);
      end else begin
         cell_calc = ftdi_pkg::CELL_BITS'(32'(tenths) - ftdi_pkg::FLOW_LO);
      end
   end

   // Distance between the two found cells and offset of the unrounded flow from the lower cell, in hundredths.
   assign dist_calc   = ftdi_pkg::DIST_BITS'(10 * (32'(above_ff) - 32'(below_ff)));
   assign dist_signed = $signed(18'(dist_calc));
   assign xoff_raw    = $signed({{2{flow_ff[15]}}, flow_ff})
                      - $signed(18'(10 * (32'(below_ff) + ftdi_pkg::FLOW_LO)));

   // The single multiplier serves both interpolation weights.
   assign mul_a = (state_ff == ST_MUL1) ? lo_ff : hi_ff;
   assign mul_b = (state_ff == ST_MUL1) ? (dist_ff - xoff_ff) : xoff_ff;
   assign mul_p = ftdi_pkg::PROD_BITS'(mul_a) * ftdi_pkg::PROD_BITS'(mul_b);

   assign div_req.start    = (state_ff == ST_DIVGO);
   assign div_req.dividend = {acc_ff, 1'b0} + ftdi_pkg::DIVIDEND_BITS'(dist_ff);
   assign div_req.divisor  = {dist_ff, 1'b0};

   ftdi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      ptr_in         = ptr_ff;
      cell_in        = cell_ff;
      below_in       = below_ff;
      above_in       = above_ff;
      below_found_in = below_found_ff;
      above_found_in = above_found_ff;
      rsp_valid_in   = rsp_valid_ff;
      flow_in        = flow_ff;
      dist_in        = dist_ff;
      xoff_in        = xoff_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      acc_in         = acc_ff;
      res_drive_in   = res_drive_ff;
      res_valid_in   = res_valid_ff;
      res_exact_in   = res_exact_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_dvalid_in  = rsp_dvalid_ff;
      rsp_exact_in   = rsp_exact_ff;
      rd_en          = 1'b0;
      rd_addr        = cell_calc;
      wr_en          = 1'b0;
      wr_addr        = wr_cell;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  ftdi_pkg::REQ_CLEAR: begin
                     valid_in = '0;
                  end
                  ftdi_pkg::REQ_WRITE: begin
                     if (wr_in_range && !(req_only_if_empty && valid_ff[wr_cell])) begin
                        wr_en             = 1'b1;
                        valid_in[wr_cell] = 1'b1;
                     end
                  end
                  ftdi_pkg::REQ_LOOKUP: begin
                     flow_in  = req_flow_centi;
                     state_in = ST_CELL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CELL: begin
            cell_in = cell_calc;
            ptr_in  = cell_calc;
            if (valid_ff[cell_calc]) begin
               rd_en    = 1'b1;
               rd_addr  = cell_calc;
               state_in = ST_HIT;
            end else begin
               state_in = ST_SCANDN;
            end
         end
         ST_SCANDN: begin
            if (valid_ff[ptr_ff]) begin
               below_in       = ptr_ff;
               below_found_in = 1'b1;
               ptr_in         = cell_ff;
               state_in       = ST_SCANUP;
            end else if (ptr_ff == '0) begin
               below_found_in = 1'b0;
               ptr_in         = cell_ff;
               state_in       = ST_SCANUP;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         ST_SCANUP: begin
            if (valid_ff[ptr_ff]) begin
               above_in       = ptr_ff;
               above_found_in = 1'b1;
               state_in       = ST_RDLO;
            end else if (ptr_ff == ftdi_pkg::CELL_BITS'(ftdi_pkg::NCELLS - 1)) begin
               above_found_in = 1'b0;
               state_in       = ST_RDLO;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_RDLO: begin
            dist_in = dist_calc;
            if (xoff_raw < 18'sd0) begin
               xoff_in = '0;
            end else if (xoff_raw > dist_signed) begin
               xoff_in = dist_calc;
            end else begin
               xoff_in = ftdi_pkg::DIST_BITS'(xoff_raw);
            end
            if (!below_found_ff && !above_found_ff) begin
               res_drive_in = '0;
               res_valid_in = 1'b0;
               res_exact_in = 1'b0;
               state_in     = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = below_found_ff ? below_ff : above_ff;
               state_in = ST_RDHI;
            end
         end
         ST_RDHI: begin
            lo_in = rd_data_ff;
            if (below_found_ff && above_found_ff) begin
               rd_en    = 1'b1;
               rd_addr  = above_ff;
               state_in = ST_MUL1;
            end else begin
               res_drive_in = ftdi_pkg::OUT_BITS'(rd_data_ff);
               res_valid_in = 1'b1;
               res_exact_in = 1'b0;
               state_in     = ST_DONE;
            end
         end
         ST_MUL1: begin
            hi_in    = rd_data_ff;
            acc_in   = mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = acc_ff + mul_p;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_drive_in = ftdi_pkg::OUT_BITS'(div_rsp.quotient);
               res_valid_in = 1'b1;
               res_exact_in = 1'b0;
               state_in     = ST_DONE;
            end
         end
         ST_HIT: begin
            res_drive_in = ftdi_pkg::OUT_BITS'(rd_data_ff);
            res_valid_in = 1'b1;
            res_exact_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_drive_in  = res_drive_ff;
               rsp_dvalid_in = res_valid_ff;
               rsp_exact_in  = res_exact_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         ptr_ff         <= '0;
         below_found_ff <= 1'b0;
         above_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         ptr_ff         <= ptr_in;
         below_found_ff <= below_found_in;
         above_found_ff <= above_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff       <= cell_in;
      below_ff      <= below_in;
      above_ff      <= above_in;
      flow_ff       <= flow_in;
      dist_ff       <= dist_in;
      xoff_ff       <= xoff_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      acc_ff        <= acc_in;
      res_drive_ff  <= res_drive_in;
      res_valid_ff  <= res_valid_in;
      res_exact_ff  <= res_exact_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_exact_ff  <= rsp_exact_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= ftdi_pkg::DRIVE_BITS'(req_drive_value);
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_out   = rsp_drive_ff;
   assign rsp_drive_valid = rsp_dvalid_ff;
   assign rsp_exact_hit   = rsp_exact_ff;

   `FTDI_ASSERT_SAME(a_empty_rsp_zero, clock, reset,
      rsp_valid && !rsp_drive_valid, (rsp_drive_out == '0) && !rsp_exact_hit,
      "Response for an empty table carries a drive value or an exact hit.")
   `FTDI_ASSERT_SAME(a_scan_ptr_range, clock, reset,
      (state_ff == ST_SCANDN) || (state_ff == ST_SCANUP),
      32'(ptr_ff) < ftdi_pkg::NCELLS,
      "Scan pointer has left the table.")
   `FTDI_ASSERT_SAME(a_div_done_state, clock, reset,
      div_rsp.done, state_ff == ST_DIV,
      "Divider finished while the sequencer was not waiting for it.")
   `FTDI_ASSERT_NEXT(a_div_started, clock, reset,
      state_ff == ST_DIVGO, div_rsp.busy,
      "Divider did not start when the sequencer requested it.")

endmodule
